@@ rtl/core/sorted_topk_list_merge_defines.svh @@
// assertion macros shared by the checker
`ifndef SORTED_TOPK_LIST_MERGE_DEFINES_SVH
`define SORTED_TOPK_LIST_MERGE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define STKM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted_topk_list_merge check failed");

// next-cycle implication
`define STKM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted_topk_list_merge check failed");

`endif

@@ rtl/core/stkm_pkg.sv @@
package stkm_pkg;

   localparam int FIELD_BITS = 32;

   typedef logic [FIELD_BITS-1:0] field_type;

   // per-request control for one list buffer
   typedef struct packed {
      logic accept;
      logic advance;
      logic restart;
   } list_ctl_type;

   typedef struct packed {
      field_type merged_distance;
      field_type merged_point;
      logic      from_fresh;
      logic      run_end;
      logic      batch_end;
   } rsp_type;

endpackage

@@ rtl/core/stkm_ifs.sv @@
interface stkm_req_if;
   import stkm_pkg::*;

   logic      valid;
   logic      ready;
   field_type kept_distance;
   field_type kept_point;
   field_type fresh_distance;
   field_type fresh_point;
   logic      last_in_list;
   logic      last_query;

   modport source (
      output valid, kept_distance, kept_point, fresh_distance, fresh_point,
             last_in_list, last_query,
      input  ready
   );
   modport sink (
      input  valid, kept_distance, kept_point, fresh_distance, fresh_point,
             last_in_list, last_query,
      output ready
   );
endinterface

interface stkm_rsp_if;
   import stkm_pkg::*;

   logic      valid;
   logic      ready;
   field_type merged_distance;
   field_type merged_point;
   logic      from_fresh;
   logic      run_end;
   logic      batch_end;

   modport source (
      output valid, merged_distance, merged_point, from_fresh, run_end, batch_end,
      input  ready
   );
   modport sink (
      input  valid, merged_distance, merged_point, from_fresh, run_end, batch_end,
      output ready
   );
endinterface

@@ rtl/core/stkm_list_buf.sv @@
module stkm_list_buf #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  stkm_pkg::list_ctl_type   ctl,
   input  logic [AW-1:0]            wr_rank,
   input  logic [DW-1:0]            wr_dist,
   input  stkm_pkg::field_type      wr_point,
   output logic [DW-1:0]            head_dist,
   output stkm_pkg::field_type      head_point
);
   import stkm_pkg::*;

   localparam int EW = DW + FIELD_BITS;

   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_ff;
   logic [EW-1:0] byp_ff;
   logic          byp_sel_ff;
   logic [AW-1:0] head_ff;
   logic [AW-1:0] head_in;
   logic [EW-1:0] wr_entry;
   logic [EW-1:0] head_entry;

   assign wr_entry = {wr_dist, wr_point};

   always_comb begin
      if (ctl.restart) begin
         head_in = '0;
      end else if (ctl.advance) begin
         head_in = head_ff + AW'(1);
      end else begin
         head_in = head_ff;
      end
   end

   // head equal to the rank being written: take the live request
   // head written in the same cycle as its read was issued: take the bypass copy
   always_comb begin
      if (head_ff == wr_rank) begin
         head_entry = wr_entry;
      end else if (byp_sel_ff) begin
         head_entry = byp_ff;
      end else begin
         head_entry = rd_ff;
      end
   end

   assign head_dist  = head_entry[EW-1:FIELD_BITS];
   assign head_point = head_entry[FIELD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         mem[wr_rank] <= wr_entry;
         rd_ff        <= mem[head_in];
         byp_ff       <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         byp_sel_ff <= 1'b0;
      end else if (ctl.accept) begin
         head_ff    <= head_in;
         byp_sel_ff <= (head_in == wr_rank);
      end
   end

endmodule

@@ rtl/core/stkm_out_skid.sv @@
module stkm_out_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  stkm_pkg::rsp_type in_data,
   stkm_rsp_if.source       rsp_ch
);
   import stkm_pkg::*;

   rsp_type out_ff;
   rsp_type skid_ff;
   logic    out_valid_ff;
   logic    skid_valid_ff;
   logic    out_free;

   assign in_ready = !skid_valid_ff;
   assign out_free = !out_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_valid;
         end
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : in_data;
      end
      if (!out_free && in_valid && !skid_valid_ff) begin
         skid_ff <= in_data;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.merged_distance = out_ff.merged_distance;
   assign rsp_ch.merged_point    = out_ff.merged_point;
   assign rsp_ch.from_fresh      = out_ff.from_fresh;
   assign rsp_ch.run_end         = out_ff.run_end;
   assign rsp_ch.batch_end       = out_ff.batch_end;

endmodule

@@ rtl/core/sorted_topk_list_merge.sv @@
// sorted top-k list merge for k-nearest-neighbor updates
// req_ch carries, per request, the rank-j entry of the kept list and of the
// fresh list for one query, with last_in_list on rank k-1 and last_query
// on the batch's final query. rsp_ch returns one merged entry per request,
// in ascending distance order; ties go to the fresh list.
// each result is registered in the output stage before it reaches rsp_ch.
// throughput: one request per cycle while req_ch.ready is high. each list
// lives in a one-port-write, one-port-read memory with a registered read,
// and the head entry for the next request is read while the current one is
// merged; heads that land on the entry just written or about to be written
// are forwarded. a run ends on last_in_list or at rank MAX_NEIGHBORS-1,
// which returns both heads and the write rank to zero.
// reset (synchronous) clears heads, rank and output state; the memories are
// not cleared and need no sweep.
// a two-deep output stage holds results while rsp_ch.ready is low; req_ch.ready
// drops only when both are full and comes from a register.
module sorted_topk_list_merge #(
   parameter int MAX_NEIGHBORS = 64,
   parameter int DIST_BITS     = 32
) (
   input  logic       clock,
   input  logic       reset,
   stkm_req_if.sink   req_ch,
   stkm_rsp_if.source rsp_ch
);
   import stkm_pkg::*;

   localparam int DW = (DIST_BITS < FIELD_BITS) ? DIST_BITS : FIELD_BITS;
   localparam int AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam logic [AW-1:0] LAST_RANK = AW'(MAX_NEIGHBORS - 1);

   logic [AW-1:0] rank_ff;
   logic          accept;
   logic          run_end;
   logic          take_kept;
   logic          skid_ready;
   list_ctl_type  kept_ctl;
   list_ctl_type  fresh_ctl;
   logic [DW-1:0] kept_dist;
   logic [DW-1:0] fresh_dist;
   field_type     kept_pt;
   field_type     fresh_pt;
   rsp_type       result;

   assign req_ch.ready = skid_ready;
   assign accept       = req_ch.valid && skid_ready;
   assign run_end      = req_ch.last_in_list || (rank_ff == LAST_RANK);
   assign take_kept    = kept_dist < fresh_dist;

   assign kept_ctl.accept   = accept;
   assign kept_ctl.advance  = take_kept;
   assign kept_ctl.restart  = run_end;
   assign fresh_ctl.accept  = accept;
   assign fresh_ctl.advance = !take_kept;
   assign fresh_ctl.restart = run_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= '0;
      end else if (accept) begin
         rank_ff <= run_end ? '0 : rank_ff + AW'(1);
      end
   end

   stkm_list_buf #(
      .DEPTH (MAX_NEIGHBORS),
      .AW    (AW),
      .DW    (DW)
   ) u_kept (
      .clock      (clock),
      .reset      (reset),
      .ctl        (kept_ctl),
      .wr_rank    (rank_ff),
      .wr_dist    (DW'(req_ch.kept_distance)),
      .wr_point   (req_ch.kept_point),
      .head_dist  (kept_dist),
      .head_point (kept_pt)
   );

   stkm_list_buf #(
      .DEPTH (MAX_NEIGHBORS),
      .AW    (AW),
      .DW    (DW)
   ) u_fresh (
      .clock      (clock),
      .reset      (reset),
      .ctl        (fresh_ctl),
      .wr_rank    (rank_ff),
      .wr_dist    (DW'(req_ch.fresh_distance)),
      .wr_point   (req_ch.fresh_point),
      .head_dist  (fresh_dist),
      .head_point (fresh_pt)
   );

   always_comb begin
      result.merged_distance = take_kept ? FIELD_BITS'(kept_dist) : FIELD_BITS'(fresh_dist);
      result.merged_point    = take_kept ? kept_pt : fresh_pt;
      result.from_fresh      = !take_kept;
      result.run_end         = run_end;
      result.batch_end       = run_end && req_ch.last_query;
   end

   stkm_out_skid u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_ready (skid_ready),
      .in_data  (result),
      .rsp_ch   (rsp_ch)
   );

endmodule

@@ rtl/core/stkm_checker.sv @@
`include "sorted_topk_list_merge_defines.svh"

module stkm_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input stkm_pkg::field_type rsp_merged_distance,
   input stkm_pkg::field_type rsp_merged_point,
   input logic                rsp_from_fresh,
   input logic                rsp_run_end,
   input logic                rsp_batch_end
);

   // a batch can only close on a run's final entry
   `STKM_ASSERT_NOW(a_batch_in_run, rsp_valid && rsp_batch_end, rsp_run_end)

   // input stalls only once the output side holds a result
   `STKM_ASSERT_NOW(a_stall_full, !req_ready, rsp_valid)

   // a request taken while the output drains shows up in the next cycle
   `STKM_ASSERT_NEXT(a_one_cycle, req_valid && req_ready && (!rsp_valid || rsp_ready),
                     rsp_valid)

   // stalled result holds
   `STKM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_merged_distance) && $stable(rsp_merged_point)
                     && $stable(rsp_from_fresh) && $stable(rsp_run_end)
                     && $stable(rsp_batch_end))

endmodule

bind sorted_topk_list_merge stkm_checker u_stkm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_merged_distance (rsp_ch.merged_distance),
   .rsp_merged_point    (rsp_ch.merged_point),
   .rsp_from_fresh      (rsp_ch.from_fresh),
   .rsp_run_end         (rsp_ch.run_end),
   .rsp_batch_end       (rsp_ch.batch_end)
);

@@ sim/sorted_topk_list_merge_test.sv @@
module sorted_topk_list_merge_test;
   import stkm_pkg::*;

   localparam int RANKS       = 64;
   localparam int ITEM_TARGET = 1250;
   localparam int QUIET_LIMIT = 4000;
   localparam int MAX_GAP     = 40;
   localparam int SHOWN_ERRS  = 10;

   typedef struct packed {
      field_type kept_distance;
      field_type kept_point;
      field_type fresh_distance;
      field_type fresh_point;
      logic      last_in_list;
      logic      last_query;
   } pair_type;

   // keeps its own copy of both list buffers and heads, queues merged entries
   class merged_entry_board;
      field_type   kept_dist[RANKS];
      field_type   kept_pt[RANKS];
      field_type   fresh_dist[RANKS];
      field_type   fresh_pt[RANKS];
      int unsigned kept_head;
      int unsigned fresh_head;
      int unsigned write_rank;
      rsp_type     merged_due[$];
      int unsigned mismatches;

      function new();
         kept_head  = 0;
         fresh_head = 0;
         write_rank = 0;
         mismatches = 0;
      endfunction

      function void note_request(pair_type p);
         int unsigned j;
         int unsigned kh;
         int unsigned fh;
         logic        take_kept;
         logic        closes;
         rsp_type     want;
         j = (write_rank < RANKS) ? write_rank : RANKS - 1;
         kept_dist[j]  = p.kept_distance;
         kept_pt[j]    = p.kept_point;
         fresh_dist[j] = p.fresh_distance;
         fresh_pt[j]   = p.fresh_point;
         kh = (kept_head < RANKS) ? kept_head : RANKS - 1;
         fh = (fresh_head < RANKS) ? fresh_head : RANKS - 1;
         // ties go to the fresh list
         take_kept = kept_dist[kh] < fresh_dist[fh];
         if (take_kept) begin
            want.merged_distance = kept_dist[kh];
            want.merged_point    = kept_pt[kh];
            kept_head            = kh + 1;
         end else begin
            want.merged_distance = fresh_dist[fh];
            want.merged_point    = fresh_pt[fh];
            fresh_head           = fh + 1;
         end
         // a list reaching the last rank closes the run without the flag
         closes = p.last_in_list || (j == RANKS - 1);
         if (closes) begin
            kept_head  = 0;
            fresh_head = 0;
            write_rank = 0;
         end else begin
            write_rank = j + 1;
         end
         want.from_fresh = !take_kept;
         want.run_end    = closes;
         want.batch_end  = closes && p.last_query;
         merged_due.push_back(want);
      endfunction

      function void check_merged(rsp_type got);
         rsp_type want;
         if (merged_due.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRS)
               $display("unexpected merged entry: dist %h point %h fresh %b end %b batch %b",
                        got.merged_distance, got.merged_point, got.from_fresh,
                        got.run_end, got.batch_end);
            return;
         end
         want = merged_due.pop_front();
         if (got.merged_distance !== want.merged_distance ||
             got.merged_point !== want.merged_point ||
             got.from_fresh !== want.from_fresh ||
             got.run_end !== want.run_end ||
             got.batch_end !== want.batch_end) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRS) begin
               $display("merged entry mismatch at %0t", $realtime);
               $display("  expected dist %h point %h fresh %b end %b batch %b",
                        want.merged_distance, want.merged_point, want.from_fresh,
                        want.run_end, want.batch_end);
               $display("  actual   dist %h point %h fresh %b end %b batch %b",
                        got.merged_distance, got.merged_point, got.from_fresh,
                        got.run_end, got.batch_end);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   stkm_req_if req_ch ();
   stkm_rsp_if rsp_ch ();

   sorted_topk_list_merge dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   merged_entry_board board = new();
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;
   int                requests_taken = 0;
   int                quiet_cycles   = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // request side monitor
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         board.note_request({req_ch.kept_distance, req_ch.kept_point,
                             req_ch.fresh_distance, req_ch.fresh_point,
                             req_ch.last_in_list, req_ch.last_query});
   end

   // result side: random stalls and checking
   always @(posedge clock) begin : result_side
      rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.merged_distance = rsp_ch.merged_distance;
         got.merged_point    = rsp_ch.merged_point;
         got.from_fresh      = rsp_ch.from_fresh;
         got.run_end         = rsp_ch.run_end;
         got.batch_end       = rsp_ch.batch_end;
         board.check_merged(got);
      end
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic push_request(input pair_type p);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.kept_distance  <= p.kept_distance;
      req_ch.kept_point     <= p.kept_point;
      req_ch.fresh_distance <= p.fresh_distance;
      req_ch.fresh_point    <= p.fresh_point;
      req_ch.last_in_list   <= p.last_in_list;
      req_ch.last_query     <= p.last_query;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      requests_taken++;
   endtask

   task automatic emit(input field_type kd, input field_type kp, input field_type fd,
                       input field_type fp, input logic last, input logic lastq);
      push_request({kd, kp, fd, fp, last, lastq});
   endtask

   function automatic field_type pick_distance(input int span);
      case (span)
         0: pick_distance = $urandom_range(15, 0);
         1: pick_distance = 32'hFFFF_FFF0 | $urandom_range(15, 0);
         default: pick_distance = $urandom;
      endcase
   endfunction

   // mostly sorted lists closed by last_in_list, some overlong, some noise
   task automatic random_query();
      int        shape;
      int        k;
      int        span;
      logic      noise;
      logic      close;
      logic      lastq;
      field_type kd[$];
      field_type fd[$];
      pair_type  p;
      shape = $urandom_range(99);
      span  = $urandom_range(3);
      noise = shape >= 85;
      close = !(shape >= 75 && shape < 85);
      lastq = $urandom_range(1);
      if (!close || $urandom_range(15) == 0)
         k = RANKS;
      else if ($urandom_range(7) == 0)
         k = $urandom_range(RANKS - 1, 13);
      else
         k = $urandom_range(12, 1);
      for (int i = 0; i < k; i++) begin
         kd.push_back(pick_distance(span));
         fd.push_back(pick_distance(($urandom_range(3) == 0) ? $urandom_range(3) : span));
      end
      if (!noise) begin
         kd.sort();
         fd.sort();
      end
      for (int i = 0; i < k; i++) begin
         p.kept_distance  = kd[i];
         p.kept_point     = $urandom;
         p.fresh_distance = fd[i];
         p.fresh_point    = $urandom;
         if (noise)
            p.last_in_list = (i == k - 1) ? ($urandom_range(3) != 0) : ($urandom_range(5) == 0);
         else
            p.last_in_list = close && (i == k - 1);
         p.last_query = (i == k - 1) ? lastq : logic'($urandom_range(1));
         push_request(p);
      end
   endtask

   initial begin : stimulus
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.kept_distance  <= '0;
      req_ch.kept_point     <= '0;
      req_ch.fresh_distance <= '0;
      req_ch.fresh_point    <= '0;
      req_ch.last_in_list   <= 1'b0;
      req_ch.last_query     <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // single-entry lists at the distance extremes, ties included
      emit(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b0);
      emit(32'h0, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      emit(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFE, 32'hAAAA_5555, 1'b1, 1'b0);
      emit(32'hFFFF_FFFF, 32'h5555_AAAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      // interleaved lists
      for (int i = 0; i < 4; i++)
         emit(2 * i, i, 2 * i + 1, 32'h100 + i, i == 3, 1'b0);
      // kept list wins every rank
      for (int i = 0; i < 4; i++)
         emit(i, 32'hFFFF_0000 + i, 32'h100 + i, 32'h200 + i, i == 3, 1'b1);
      // fresh list wins every rank
      for (int i = 0; i < 4; i++)
         emit(32'hFFFF_FFF0 + i, 32'h300 + i, i, 32'h400 + i, i == 3, i[0]);
      // equal lists, so a compare ties whenever both heads sit on the same rank
      for (int i = 0; i < 4; i++)
         emit(5 * i, 32'h500 + i, 5 * i, 32'h600 + i, i == 3, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         while (requests_taken < (phase + 1) * ITEM_TARGET / 4)
            random_query();
      end
      req_ch.valid <= 1'b0;

      while (board.merged_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/stkm_pkg.sv
rtl/core/stkm_ifs.sv
rtl/core/stkm_list_buf.sv
rtl/core/stkm_out_skid.sv
rtl/core/sorted_topk_list_merge.sv
rtl/core/stkm_checker.sv
sim/sorted_topk_list_merge_test.sv
